// File: rtl/ebv_pkg.sv
// Shared types and constants for the extension block validator.
// Depends on nothing; every other file of the block imports it.
package ebv_pkg;

  // Default width of the block byte counter
  localparam int unsigned BLOCK_LEN_BITS_DEF = 16;

  // Widths of the transaction fields
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ACC_W  = 32;
  localparam int unsigned ID_W   = 31;
  localparam int unsigned GRP_W  = 3;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Varint constants
  localparam logic [ACC_W-1:0] ACC_LIMIT  = 32'h01FF_FFFF;  // all ones >> 7
  localparam logic [GRP_W-1:0] MAX_GROUPS = 3'd5;
  localparam int unsigned      CONT_BIT   = 7;

  typedef enum logic [2:0] {
    EV_CONSUMED = 3'd0,
    EV_HEADER   = 3'd1,
    EV_VALUE    = 3'd2,
    EV_ERROR    = 3'd3,
    EV_IGNORED  = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TRUNC    = 2'd1,
    ERR_RANGE    = 2'd2,
    ERR_NONCANON = 2'd3
  } err_e;

  typedef struct packed {
    logic              cmd;
    logic [LEN_W-1:0]  blk_len;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        event_res;
    logic [ID_W-1:0]   ext_id;
    logic              critical;
    logic [LEN_W-1:0]  value_len;
    logic [BYTE_W-1:0] value_byte;
    logic [LEN_W-1:0]  value_index;
    logic [1:0]        error_code;
    logic              block_done;
  } out_item_t;

endpackage

// File: rtl/ebv_in_stage.sv
// Input register stage of the extension block validator.
// Depends on ebv_pkg for the input transaction type.
module ebv_in_stage
  import ebv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  output logic     in_stall_o,
  input  logic     adv_i,
  output logic     s1_valid_o,
  output in_item_t s1_item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  // Take a new transaction when the stage is empty or drains this cycle
  assign take       = in_valid_i && (!valid_q || adv_i);
  assign in_stall_o = valid_q && !adv_i;
  assign valid_d    = take || (valid_q && !adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold payload unless a new transaction is taken
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_item_o  = item_q;

endmodule

// File: rtl/ebv_parser.sv
// Block parser: holds the block and varint state and decodes one byte a cycle while fire_i is high.
// Depends on ebv_pkg for transaction types, codes and varint constants.
module ebv_parser
  import ebv_pkg::*;
#(
  parameter int unsigned BLOCK_LEN_BITS = BLOCK_LEN_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  typedef enum logic [2:0] {
    PH_KEY = 3'b001,
    PH_LEN = 3'b010,
    PH_VAL = 3'b100
  } phase_e;

  logic                      open_q, open_d;
  phase_e                    phase_q, phase_d;
  logic [ACC_W-1:0]          acc_q, acc_d;
  logic [GRP_W-1:0]          groups_q, groups_d;
  logic [BLOCK_LEN_BITS-1:0] left_q, left_d;
  logic [ID_W-1:0]           cur_id_q, cur_id_d;
  logic                      crit_q, crit_d;
  logic [LEN_W-1:0]          vleft_q, vleft_d;
  logic [LEN_W-1:0]          vpos_q, vpos_d;
  logic [ID_W-1:0]           last_id_q, last_id_d;
  logic                      seen_q, seen_d;

  logic [ACC_W-1:0]          acc_new;
  logic [GRP_W-1:0]          groups_new;
  logic [BLOCK_LEN_BITS-1:0] left_dec;
  logic [ID_W-1:0]           key_id;
  logic [LEN_W-1:0]          len_val;
  logic [BYTE_W-1:0]         b;

  // Fewest 7-bit groups that can carry the value
  function automatic logic [GRP_W-1:0] min_groups(input logic [ACC_W-1:0] v);
    logic [GRP_W-1:0] n;
    if (v[31:28] != '0) begin
      n = 3'd5;
    end else if (v[27:21] != '0) begin
      n = 3'd4;
    end else if (v[20:14] != '0) begin
      n = 3'd3;
    end else if (v[13:7] != '0) begin
      n = 3'd2;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

  assign b          = item_i.data_byte;
  assign acc_new    = {acc_q[ACC_W-8:0], b[6:0]};
  assign groups_new = groups_q + GRP_W'(1);
  assign left_dec   = left_q - BLOCK_LEN_BITS'(1);
  assign key_id     = acc_new[ACC_W-1:1];
  assign len_val    = acc_new[LEN_W-1:0];

  // Decode one transaction against the current state
  always_comb begin
    open_d    = open_q;
    phase_d   = phase_q;
    acc_d     = acc_q;
    groups_d  = groups_q;
    left_d    = left_q;
    cur_id_d  = cur_id_q;
    crit_d    = crit_q;
    vleft_d   = vleft_q;
    vpos_d    = vpos_q;
    last_id_d = last_id_q;
    seen_d    = seen_q;

    result_o             = '0;
    result_o.event_res   = EV_CONSUMED;
    result_o.error_code  = ERR_NONE;

    if (item_i.cmd == CMD_START) begin
      // Open a fresh block, drop any old one
      phase_d   = PH_KEY;
      acc_d     = '0;
      groups_d  = '0;
      cur_id_d  = '0;
      crit_d    = 1'b0;
      vleft_d   = '0;
      vpos_d    = '0;
      last_id_d = '0;
      seen_d    = 1'b0;
      left_d    = BLOCK_LEN_BITS'(item_i.blk_len);
      open_d    = (left_d != '0);
      result_o.block_done = (left_d == '0);
    end else if (!open_q || left_q == '0) begin
      result_o.event_res = EV_IGNORED;
    end else begin
      left_d = left_dec;
      if (phase_q == PH_VAL) begin
        // Pass a value byte through
        vpos_d  = vpos_q + LEN_W'(1);
        vleft_d = vleft_q - LEN_W'(1);
        if (vleft_d == '0) begin
          phase_d = PH_KEY;
        end
        if (left_dec == '0) begin
          open_d = 1'b0;
        end
        result_o.event_res   = EV_VALUE;
        result_o.value_byte  = b;
        result_o.value_index = vpos_q;
        result_o.block_done  = (left_dec == '0);
      end else if (acc_q > ACC_LIMIT) begin
        open_d              = 1'b0;
        result_o.event_res  = EV_ERROR;
        result_o.error_code = ERR_RANGE;
      end else begin
        acc_d    = acc_new;
        groups_d = groups_new;
        if (b[CONT_BIT]) begin
          // Continuation group
          if (groups_new >= MAX_GROUPS) begin
            open_d              = 1'b0;
            result_o.event_res  = EV_ERROR;
            result_o.error_code = ERR_RANGE;
          end else if (left_dec == '0) begin
            open_d              = 1'b0;
            result_o.event_res  = EV_ERROR;
            result_o.error_code = ERR_TRUNC;
          end
        end else if (min_groups(acc_new) != groups_new) begin
          open_d              = 1'b0;
          result_o.event_res  = EV_ERROR;
          result_o.error_code = ERR_NONCANON;
        end else if (phase_q != PH_LEN) begin
          // Key varint ends: check id order, then move to the length
          if (key_id == '0 || (seen_q && key_id <= last_id_q)) begin
            open_d              = 1'b0;
            result_o.event_res  = EV_ERROR;
            result_o.error_code = ERR_NONCANON;
          end else if (left_dec == '0) begin
            open_d              = 1'b0;
            result_o.event_res  = EV_ERROR;
            result_o.error_code = ERR_TRUNC;
          end else begin
            cur_id_d = key_id;
            crit_d   = acc_new[0];
            vleft_d  = '0;
            acc_d    = '0;
            groups_d = '0;
            phase_d  = PH_LEN;
          end
        end else if (acc_new > ACC_W'(left_dec)) begin
          open_d              = 1'b0;
          result_o.event_res  = EV_ERROR;
          result_o.error_code = ERR_TRUNC;
        end else begin
          // Length varint ends: report the header
          vleft_d   = len_val;
          vpos_d    = '0;
          last_id_d = cur_id_q;
          seen_d    = 1'b1;
          acc_d     = '0;
          groups_d  = '0;
          phase_d   = (len_val != '0) ? PH_VAL : PH_KEY;
          if (left_dec == '0) begin
            open_d = 1'b0;
          end
          result_o.event_res  = EV_HEADER;
          result_o.block_done = (left_dec == '0);
        end
      end
    end

    result_o.ext_id    = cur_id_d;
    result_o.critical  = crit_d;
    result_o.value_len = vleft_d;
  end

  // Advance state on each processed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= 1'b0;
      phase_q   <= PH_KEY;
      acc_q     <= '0;
      groups_q  <= '0;
      left_q    <= '0;
      cur_id_q  <= '0;
      crit_q    <= 1'b0;
      vleft_q   <= '0;
      vpos_q    <= '0;
      last_id_q <= '0;
      seen_q    <= 1'b0;
    end else if (fire_i) begin
      open_q    <= open_d;
      phase_q   <= phase_d;
      acc_q     <= acc_d;
      groups_q  <= groups_d;
      left_q    <= left_d;
      cur_id_q  <= cur_id_d;
      crit_q    <= crit_d;
      vleft_q   <= vleft_d;
      vpos_q    <= vpos_d;
      last_id_q <= last_id_d;
      seen_q    <= seen_d;
    end
  end

endmodule

// File: rtl/ebv_out_stage.sv
// Result register stage of the extension block validator.
// Depends on ebv_pkg for the result transaction type.
module ebv_out_stage
  import ebv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t result_i,
  output logic      ready_o,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  logic      out_stall_i
);

  logic      valid_q, valid_d;
  out_item_t item_q;

  // Free when empty or when the held transaction leaves this cycle
  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the result while stalled
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// File: rtl/extension_block_validator_core.sv
// Extension block validator: checks a block of key/length/value extensions.
// An accepted input transaction passes the input register, then the result register.
// Throughput: one transaction per cycle while no result is stalled.
// A stalled result holds the pipeline; the input stalls once both registers are full and the result is stalled.
// Reset clears the pipeline valids and all block state (no block open).
// Depends on ebv_pkg, ebv_in_stage, ebv_parser and ebv_out_stage.
module extension_block_validator_core
  import ebv_pkg::*;
#(
  parameter int unsigned BLOCK_LEN_BITS = BLOCK_LEN_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_item_t  in_item_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  logic      out_stall_i
);

  logic      s1_valid;
  in_item_t  s1_item;
  logic      out_ready;
  logic      fire;
  out_item_t result;

  // Process the held transaction when the result register is free
  assign fire = s1_valid && out_ready;

  ebv_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .adv_i      (fire),
    .s1_valid_o (s1_valid),
    .s1_item_o  (s1_item)
  );

  ebv_parser #(
    .BLOCK_LEN_BITS (BLOCK_LEN_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (s1_item),
    .result_o (result)
  );

  ebv_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// File: rtl/ebv_checker.sv
// Port-level checker for the extension block validator, bound to the top level.
// Depends on ebv_pkg for transaction types and codes.
module ebv_checker
  import ebv_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input out_item_t out_item_o,
  input logic      out_stall_i
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // A valid result follows an accepted transaction, past the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##1 out_valid_o)
    else $error("no result after accepted transaction");

  // Error code present exactly on error events
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.event_res == EV_ERROR) ==
                     (out_item_o.error_code != ERR_NONE)))
    else $error("error code does not match event");

  // Block done only on consuming, header or value events
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.block_done |->
      out_item_o.event_res == EV_CONSUMED || out_item_o.event_res == EV_HEADER ||
      out_item_o.event_res == EV_VALUE)
    else $error("block done on wrong event");

endmodule

bind extension_block_validator_core ebv_checker u_ebv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_item_o  (out_item_o),
  .out_stall_i (out_stall_i)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for extension_block_validator_core: directed rows, then random
// extension blocks with corruptions, checked against an in-bench parser. Depends on ebv_pkg.
module tb_top;
  import ebv_pkg::*;

  localparam int QUIET_LIMIT   = 5000;  // cycles with no transaction before giving up
  localparam int HOLD_OFF_CYC  = 300;   // long receiver hold-off
  localparam int RANDOM_ITEMS  = 1900;
  localparam int DRAIN_CYC     = 20;

  typedef enum logic [1:0] {
    PH_KEY = 2'd0,
    PH_LEN = 2'd1,
    PH_VAL = 2'd2
  } parse_phase_e;

  typedef struct packed {
    logic        cmd;
    logic [15:0] arg;
    logic        pin;
    event_e      ev;
    err_e        err;
    logic        done;
  } dir_row_t;

  // Directed rows: pinned rows carry the result type, error code and done flag
  localparam dir_row_t DIR_ROWS [37] = '{
    '{CMD_DATA,  16'h00FF, 1'b1, EV_IGNORED,  ERR_NONE,     1'b0},  // no block open
    '{CMD_START, 16'h0000, 1'b1, EV_CONSUMED, ERR_NONE,     1'b1},  // empty block
    '{CMD_START, 16'hFFFF, 1'b1, EV_CONSUMED, ERR_NONE,     1'b0},  // longest block
    '{CMD_DATA,  16'h008F, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},  // key 0xFFFFFFFF
    '{CMD_DATA,  16'h00FF, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h00FF, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h00FF, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h007F, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0001, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},  // length 1
    '{CMD_DATA,  16'h00AA, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},  // value byte
    '{CMD_DATA,  16'h0002, 1'b1, EV_ERROR,    ERR_NONCANON, 1'b0},  // id not ascending
    '{CMD_START, 16'h0005, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0081, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0080, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0080, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0080, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0080, 1'b1, EV_ERROR,    ERR_RANGE,    1'b0},  // fifth continuation
    '{CMD_START, 16'h0005, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0090, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0080, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0080, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0080, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0000, 1'b1, EV_ERROR,    ERR_RANGE,    1'b0},  // accumulator overflow
    '{CMD_START, 16'h0001, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0080, 1'b1, EV_ERROR,    ERR_TRUNC,    1'b0},  // varint open at end
    '{CMD_START, 16'h0001, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0000, 1'b1, EV_ERROR,    ERR_NONCANON, 1'b0},  // zero id
    '{CMD_START, 16'h0001, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0002, 1'b1, EV_ERROR,    ERR_TRUNC,    1'b0},  // key ends at end
    '{CMD_START, 16'h0003, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0080, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_START, 16'h0002, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},  // abandon open block
    '{CMD_DATA,  16'h0002, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0005, 1'b1, EV_ERROR,    ERR_TRUNC,    1'b0},  // length beyond block
    '{CMD_START, 16'h0002, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0080, 1'b0, EV_CONSUMED, ERR_NONE,     1'b0},
    '{CMD_DATA,  16'h0002, 1'b1, EV_ERROR,    ERR_NONCANON, 1'b0}   // long form
  };

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  in_item_t  in_item_i;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;
  logic      out_stall_i;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  // Parser mirror state
  logic         p_open;
  parse_phase_e p_phase;
  logic [31:0]  p_acc;
  int           p_groups;
  logic [15:0]  p_left;
  logic [30:0]  p_id;
  logic         p_crit;
  logic [15:0]  p_vleft;
  logic [15:0]  p_vpos;
  logic [30:0]  p_last_id;
  logic         p_seen;

  out_item_t pending_results[$];
  int        parsed_cnt;
  int        err_cnt;
  int        quiet_cyc;
  int        idle_pct;
  int        stall_pct;
  int        hold_cnt;
  bit        hold_off_req;

  // Pinned expectation of the transaction on offer
  bit        pin_on;
  event_e    pin_ev;
  err_e      pin_err;
  bit        pin_done;

  // Random block under construction
  logic [7:0] blk_bytes[$];
  int         key_pos[$];
  int         var_pos[$];

  extension_block_validator_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_parser();
    p_open    = 1'b0;
    p_phase   = PH_KEY;
    p_acc     = '0;
    p_groups  = 0;
    p_left    = '0;
    p_id      = '0;
    p_crit    = 1'b0;
    p_vleft   = '0;
    p_vpos    = '0;
    p_last_id = '0;
    p_seen    = 1'b0;
  endfunction

  // Fewest 7-bit groups that hold v
  function automatic int groups_needed(logic [31:0] v);
    int n = 1;
    while (v >= 32'h80) begin
      v = v >> 7;
      n++;
    end
    return n;
  endfunction

  // Advance the parser mirror by one transaction and return its result
  function automatic out_item_t validate_item(in_item_t it);
    out_item_t   r;
    err_e        err;
    logic [30:0] id;
    r = '0;
    err = ERR_NONE;
    r.event_res = EV_CONSUMED;
    if (it.cmd == CMD_START) begin
      clear_parser();
      p_left = it.blk_len;
      p_open = (p_left != 0);
      r.block_done = (p_left == 0);
    end else if (!p_open || p_left == 0) begin
      r.event_res = EV_IGNORED;
    end else begin
      p_left = p_left - 16'd1;
      if (p_phase == PH_VAL) begin
        r.event_res   = EV_VALUE;
        r.value_byte  = it.data_byte;
        r.value_index = p_vpos;
        p_vpos  = p_vpos + 16'd1;
        p_vleft = p_vleft - 16'd1;
        if (p_vleft == 0) p_phase = PH_KEY;
        if (p_left == 0) p_open = 1'b0;
        r.block_done = (p_left == 0);
      end else if (p_acc > ACC_LIMIT) begin
        err = ERR_RANGE;
      end else begin
        p_acc = {p_acc[24:0], it.data_byte[6:0]};
        p_groups++;
        if (it.data_byte[CONT_BIT]) begin
          if (p_groups >= MAX_GROUPS) err = ERR_RANGE;
          else if (p_left == 0) err = ERR_TRUNC;
        end else if (groups_needed(p_acc) != p_groups) begin
          err = ERR_NONCANON;
        end else if (p_phase != PH_LEN) begin
          id = p_acc[31:1];
          if (id == 0 || (p_seen && id <= p_last_id)) begin
            err = ERR_NONCANON;
          end else if (p_left == 0) begin
            err = ERR_TRUNC;
          end else begin
            p_id     = id;
            p_crit   = p_acc[0];
            p_vleft  = '0;
            p_acc    = '0;
            p_groups = 0;
            p_phase  = PH_LEN;
          end
        end else if (p_acc > {16'd0, p_left}) begin
          err = ERR_TRUNC;
        end else begin
          p_vleft   = p_acc[15:0];
          p_vpos    = '0;
          p_last_id = p_id;
          p_seen    = 1'b1;
          p_acc     = '0;
          p_groups  = 0;
          p_phase   = (p_vleft != 0) ? PH_VAL : PH_KEY;
          if (p_left == 0) p_open = 1'b0;
          r.event_res  = EV_HEADER;
          r.block_done = (p_left == 0);
        end
      end
    end
    // The first error closes the block
    if (err != ERR_NONE) begin
      p_open       = 1'b0;
      r.event_res  = EV_ERROR;
      r.error_code = err;
      r.block_done = 1'b0;
    end
    r.ext_id    = p_id;
    r.critical  = p_crit;
    r.value_len = p_vleft;
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // Predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    out_item_t pred;
    out_item_t want;
    if (in_fire) begin
      pred = validate_item(in_item_i);
      if (pin_on) begin
        pred.event_res  = pin_ev;
        pred.error_code = pin_err;
        pred.block_done = pin_done;
      end
      parsed_cnt++;
      pending_results.push_back(pred);
    end
    if (out_fire) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("event_res", want.event_res, out_item_o.event_res);
        check_field("ext_id", want.ext_id, out_item_o.ext_id);
        check_field("critical", want.critical, out_item_o.critical);
        check_field("value_len", want.value_len, out_item_o.value_len);
        check_field("value_byte", want.value_byte, out_item_o.value_byte);
        check_field("value_index", want.value_index, out_item_o.value_index);
        check_field("error_code", want.error_code, out_item_o.error_code);
        check_field("block_done", want.block_done, out_item_o.block_done);
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire) quiet_cyc = 0;
    else quiet_cyc++;
    if (quiet_cyc >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cnt > 0) begin
        out_stall_i <= 1'b1;
        hold_cnt--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_cnt = HOLD_OFF_CYC - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic in_item_t mk_item(logic cmd, logic [15:0] arg);
    in_item_t it;
    it.cmd = cmd;
    it.blk_len = (cmd == CMD_START) ? arg : 16'($urandom);
    it.data_byte = (cmd == CMD_START) ? 8'($urandom) : arg[7:0];
    return it;
  endfunction

  // Offer one transaction after random idle cycles, hold it until accepted
  task automatic send_item(in_item_t it, bit pin = 1'b0, event_e ev = EV_CONSUMED,
                           err_e err = ERR_NONE, bit done = 1'b0);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    pin_on   = pin;
    pin_ev   = ev;
    pin_err  = err;
    pin_done = done;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stop offering and wait for every pending result
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // MSB-first varint, continuation flag on every group but the last
  function automatic void put_varint(logic [31:0] v);
    int n;
    n = groups_needed(v);
    var_pos.push_back(blk_bytes.size());
    for (int i = n - 1; i >= 0; i--) begin
      blk_bytes.push_back({i != 0, 7'(v >> (7 * i))});
    end
  endfunction

  // Build a well-formed block, sometimes corrupt it, then send it
  task automatic random_block();
    int              n_ext;
    int              vlen;
    int              blen;
    int              pos;
    int              cut;
    longint unsigned next_id;
    logic [30:0]     id;
    logic [7:0]      ins[$];
    blk_bytes.delete();
    key_pos.delete();
    var_pos.delete();
    id = '0;
    n_ext = $urandom_range(0, 4);
    for (int e = 0; e < n_ext; e++) begin
      case ($urandom_range(0, 3))
        0: next_id = id + 1;
        1: next_id = id + $urandom_range(1, 100);
        2: next_id = id + $urandom_range(1, 1 << 20);
        default: next_id = id + 1 + $urandom_range(0, 32'h7FFF_FFFF);
      endcase
      if (next_id > 64'h7FFF_FFFF) next_id = 64'h7FFF_FFFF;
      if (next_id <= id) break;
      id = next_id[30:0];
      key_pos.push_back(blk_bytes.size());
      put_varint({id, 1'($urandom_range(0, 1))});
      vlen = ($urandom_range(0, 11) == 0) ? $urandom_range(6, 300) : $urandom_range(0, 5);
      put_varint(vlen);
      repeat (vlen) blk_bytes.push_back(8'($urandom));
    end
    blen = blk_bytes.size();
    if ($urandom_range(0, 99) < 30) begin
      pos = (var_pos.size() != 0) ? var_pos[$urandom_range(0, var_pos.size() - 1)] : 0;
      case ($urandom_range(0, 6))
        0: begin
          // wrong block length
          if ($urandom_range(0, 1) && blen > 0) blen = $urandom_range(0, blen - 1);
          else blen = blen + $urandom_range(1, 4);
        end
        1: begin
          if (blk_bytes.size() != 0) begin
            cut = $urandom_range(0, blk_bytes.size() - 1);
            blk_bytes[cut] = blk_bytes[cut] ^ 8'($urandom_range(1, 255));
          end
        end
        2: ins = '{8'h80};                                  // leading zero group
        3: ins = '{8'h90, 8'h80, 8'h80, 8'h80};             // accumulator overflow
        4: ins = '{8'h81, 8'h80, 8'h80, 8'h80, 8'h80};      // fifth continuation
        5: begin
          // zero or repeated low id
          if (key_pos.size() != 0) pos = key_pos[$urandom_range(0, key_pos.size() - 1)];
          ins = '{8'($urandom_range(0, 3))};
        end
        default: begin
          // cut short, the next start abandons the block
          cut = $urandom_range(0, blk_bytes.size());
          while (blk_bytes.size() > cut) void'(blk_bytes.pop_back());
        end
      endcase
      foreach (ins[k]) blk_bytes.insert(pos + k, ins[k]);
      blen = blen + ins.size();
    end
    send_item(mk_item(CMD_START, 16'(blen)));
    foreach (blk_bytes[k]) send_item(mk_item(CMD_DATA, {8'd0, blk_bytes[k]}));
  endtask

  // Random transactions, mostly data bytes
  task automatic random_noise();
    repeat ($urandom_range(1, 8)) begin
      send_item(mk_item(($urandom_range(0, 3) != 0) ? CMD_DATA : CMD_START, 16'($urandom)));
    end
  endtask

  initial begin
    int idle_by_phase[4];
    int stall_by_phase[4];
    int base;
    idle_by_phase  = '{0, 83, 0, 29};
    stall_by_phase = '{0, 0, 83, 29};
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    pin_on       = 1'b0;
    pin_ev       = EV_CONSUMED;
    pin_err      = ERR_NONE;
    pin_done     = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_cnt     = 0;
    hold_off_req = 1'b0;
    parsed_cnt   = 0;
    err_cnt      = 0;
    quiet_cyc    = 0;
    clear_parser();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed rows
    foreach (DIR_ROWS[r]) begin
      send_item(mk_item(DIR_ROWS[r].cmd, DIR_ROWS[r].arg), DIR_ROWS[r].pin,
                DIR_ROWS[r].ev, DIR_ROWS[r].err, DIR_ROWS[r].done);
    end
    drain();

    // Random blocks and noise, one idling profile per phase
    base = parsed_cnt;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      if (ph == 0) hold_off_req = 1'b1;
      while (parsed_cnt < base + RANDOM_ITEMS * (ph + 1) / 4) begin
        if ($urandom_range(0, 3) != 0) random_block();
        else random_noise();
      end
      drain();
    end

    repeat (DRAIN_CYC) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
